### rtl/core/lpkit_pkg.sv
// Shared types and constants for the linear-probe key index table.
// Request/response payloads and the controller <-> datapath command bundles.
// No dependencies.
package lpkit_pkg;

  localparam int unsigned KeyW        = 32;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned DataSlotW   = 10;
  localparam int unsigned EntryCountW = 11;

  // Request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Response status codes
  localparam logic [StatusW-1:0] STS_NEW     = 3'd0;
  localparam logic [StatusW-1:0] STS_UPDATED = 3'd1;
  localparam logic [StatusW-1:0] STS_FULL    = 3'd2;
  localparam logic [StatusW-1:0] STS_FOUND   = 3'd3;
  localparam logic [StatusW-1:0] STS_ABSENT  = 3'd4;
  localparam logic [StatusW-1:0] STS_ZERO    = 3'd5;
  localparam logic [StatusW-1:0] STS_CLEARED = 3'd6;

  // Running minimum starts at the largest signed key
  localparam logic signed [KeyW-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]             mode;
    logic signed [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]     status;
    logic [DataSlotW-1:0]   data_slot;
    logic [EntryCountW-1:0] entry_count;
    logic signed [KeyW-1:0] min_key;
    logic signed [KeyW-1:0] max_key;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic               cap;         // latch request key
    logic               clr_regs;    // clear count, min/max, rewind pointer
    logic               minmax;      // update running min/max from request key
    logic               hash_start;  // start home slot computation
    logic               probe_init;  // load pointer with home slot
    logic               rd;          // read table at pointer
    logic               adv;         // step pointer to next slot
    logic               hit;         // latch data index of matching slot
    logic               ins;         // write key and new data index at pointer
    logic               sweep_step;  // zero key at pointer, step pointer
    logic               res;         // load response register
    logic [StatusW-1:0] res_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hash_done;
    logic key_match;
    logic slot_empty;
    logic last_probe;
    logic last_slot;
    logic full;
  } sts_t;

endpackage

### rtl/core/linear_probe_key_index_table_core.sv
// Linear-probe key index table: top level joining controller and datapath.
// Sequencing: after reset the block runs a clearing pass over every slot with in_ready_o
// low. Insert and find step through the probed slots, each read through the registered
// read port of the key memory and then checked; a miss on find probes every slot. Sizes
// that are not a power of two add stages for the slot remainder (reciprocal multiply and
// correction). Clear zeroes one slot per cycle; zero keys and inserts into a full table
// go straight to the response. One request is worked at a time; a finished response sits
// in an output register, so the next request is taken while it waits.
module linear_probe_key_index_table_core #(
  parameter int unsigned MaxKeys    = 1024,
  parameter int unsigned TableSlots = 2048
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lpkit_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lpkit_pkg::rsp_t out_rsp_o
);
  import lpkit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lpkit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpkit_dp #(
    .MaxKeys   (MaxKeys),
    .TableSlots(TableSlots)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req_i(in_req_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .rsp_o   (out_rsp_o)
  );

endmodule

### rtl/core/lpkit_hash.sv
// Home slot unit: three-stage integer mix, then reduction to a table slot.
// Power-of-two sizes take the low bits; other sizes use a reciprocal multiply and correction.
// Depends on lpkit_pkg.
module lpkit_hash #(
  parameter int unsigned TableSlots = 2048
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  logic signed [lpkit_pkg::KeyW-1:0]      key_i,
  output logic                                   done_o,
  output logic [$clog2(TableSlots)-1:0]          slot_o
);
  import lpkit_pkg::*;

  localparam int unsigned SlotW  = $clog2(TableSlots);
  localparam bit          IsPow2 = (TableSlots & (TableSlots - 1)) == 0;

  logic signed [KeyW-1:0] t1, t2, t3;
  logic signed [KeyW-1:0] s1_d, s2_d, s3_d;
  logic signed [KeyW-1:0] s1_q, s2_q, s3_q;
  logic                   v1_q, v2_q, v3_q;

  // Mix: each stage adds shifted copies of its input, then xors in a right shift
  always_comb begin
    t1   = ~key_i + (key_i << 15);
    s1_d = t1 ^ (t1 >>> 12);
    t2   = s1_q + (s1_q << 2);
    s2_d = t2 ^ (t2 >>> 4);
    t3   = s2_q + (s2_q << 3) + (s2_q << 11);  // times 2057
    s3_d = t3 ^ (t3 >>> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) s1_q <= s1_d;
    if (v1_q)    s2_q <= s2_d;
    if (v2_q)    s3_q <= s3_d;
  end

  if (IsPow2) begin : g_pow2
    // Low bits equal the nonnegative remainder
    assign done_o = v3_q;
    assign slot_o = s3_q[SlotW-1:0];
  end else begin : g_div
    // Scaled reciprocal: the quotient estimate is exact or one low (magnitude <= 2^31)
    localparam logic [2*KeyW-1:0] RecipFull = (64'd1 << KeyW) / TableSlots;
    localparam logic [KeyW-1:0]   Recip     = RecipFull[KeyW-1:0];
    localparam logic [KeyW-1:0]   Modulus   = KeyW'(TableSlots);

    logic              m1_q, m2_q, m3_q, fin_q, neg_q;
    logic [KeyW-1:0]   mag_q, est_q, red_q;
    logic [2*KeyW-1:0] prod_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m1_q  <= 1'b0;
        m2_q  <= 1'b0;
        m3_q  <= 1'b0;
        fin_q <= 1'b0;
      end else begin
        m1_q  <= v3_q;
        m2_q  <= m1_q;
        m3_q  <= m2_q;
        fin_q <= m3_q;
      end
    end

    // Magnitude, quotient estimate, remainder estimate, one corrective subtract
    always_ff @(posedge clk_i) begin
      if (v3_q) begin
        neg_q <= s3_q[KeyW-1];
        mag_q <= s3_q[KeyW-1] ? KeyW'(-s3_q) : KeyW'(s3_q);
      end
      if (m1_q) prod_q <= (2*KeyW)'(mag_q) * (2*KeyW)'(Recip);
      if (m2_q) est_q  <= mag_q - prod_q[2*KeyW-1:KeyW] * Modulus;
      if (m3_q) red_q  <= (est_q >= Modulus) ? est_q - Modulus : est_q;
    end

    assign done_o = fin_q;
    // Negative mix: fold the remainder back into range
    assign slot_o = (neg_q && red_q != '0) ? SlotW'(Modulus - red_q) : SlotW'(red_q);
  end

endmodule

### rtl/core/lpkit_dp.sv
// Datapath: slot key/data memories, probe pointer, counters, min/max, response.
// Acts only on commands from lpkit_ctrl; holds the home slot unit.
// Depends on lpkit_pkg and lpkit_hash.
module lpkit_dp #(
  parameter int unsigned MaxKeys    = 1024,
  parameter int unsigned TableSlots = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpkit_pkg::req_t   in_req_i,
  input  lpkit_pkg::cmd_t   cmd_i,
  output lpkit_pkg::sts_t   sts_o,
  output lpkit_pkg::rsp_t   rsp_o
);
  import lpkit_pkg::*;

  localparam int unsigned SlotW = $clog2(TableSlots);
  localparam int unsigned IdxW  = $clog2(MaxKeys);
  localparam int unsigned CntW  = $clog2(MaxKeys + 1);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(TableSlots - 1);
  localparam logic [CntW-1:0]  CntMax   = CntW'(MaxKeys);

  logic [KeyW-1:0]        key_mem [TableSlots];
  logic [IdxW-1:0]        idx_mem [TableSlots];

  logic signed [KeyW-1:0] key_q;
  logic [KeyW-1:0]        rkey_q;
  logic [IdxW-1:0]        ridx_q;
  logic [IdxW-1:0]        hit_idx_q;
  logic [SlotW-1:0]       pos_q, pos_next, n_q;
  logic [CntW-1:0]        count_q;
  logic signed [KeyW-1:0] min_q, max_q;
  rsp_t                   rsp_q;
  logic                   hash_done;
  logic [SlotW-1:0]       hash_slot;
  logic                   has_slot;

  lpkit_hash #(
    .TableSlots(TableSlots)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.hash_start),
    .key_i  (in_req_i.key),
    .done_o (hash_done),
    .slot_o (hash_slot)
  );

  // Next slot with wraparound
  assign pos_next = (pos_q == SlotLast) ? '0 : pos_q + 1'b1;

  // Table memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step) begin
      key_mem[pos_q] <= '0;
    end else if (cmd_i.ins) begin
      key_mem[pos_q] <= key_q;
      idx_mem[pos_q] <= IdxW'(count_q);
    end
    if (cmd_i.rd) begin
      rkey_q <= key_mem[pos_q];
      ridx_q <= idx_mem[pos_q];
    end
  end

  // Pointer, probe counter, entry count, min/max
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      n_q     <= '0;
      count_q <= '0;
      min_q   <= KEY_MAX;
      max_q   <= '0;
    end else begin
      if (cmd_i.clr_regs) begin
        pos_q   <= '0;
        count_q <= '0;
        min_q   <= KEY_MAX;
        max_q   <= '0;
      end
      if (cmd_i.minmax) begin
        if ($signed(in_req_i.key) < min_q) min_q <= in_req_i.key;
        if (max_q < $signed(in_req_i.key)) max_q <= in_req_i.key;
      end
      if (cmd_i.sweep_step || cmd_i.adv) pos_q <= pos_next;
      if (cmd_i.probe_init) begin
        pos_q <= hash_slot;
        n_q   <= '0;
      end else if (cmd_i.adv) begin
        n_q <= n_q + 1'b1;
      end
      if (cmd_i.ins) count_q <= count_q + 1'b1;
    end
  end

  // Request key and matched data index
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) key_q <= in_req_i.key;
    if (cmd_i.hit) hit_idx_q <= ridx_q;
    else if (cmd_i.ins) hit_idx_q <= IdxW'(count_q);
  end

  // Response register
  assign has_slot = (cmd_i.res_status == STS_NEW) || (cmd_i.res_status == STS_UPDATED) ||
                    (cmd_i.res_status == STS_FOUND);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res) begin
      rsp_q.status      <= cmd_i.res_status;
      rsp_q.data_slot   <= has_slot ? DataSlotW'(hit_idx_q) : '0;
      rsp_q.entry_count <= EntryCountW'(count_q);
      rsp_q.min_key     <= min_q;
      rsp_q.max_key     <= max_q;
    end
  end

  assign rsp_o = rsp_q;

  always_comb begin
    sts_o.hash_done  = hash_done;
    sts_o.key_match  = rkey_q == key_q;
    sts_o.slot_empty = rkey_q == '0;
    sts_o.last_probe = n_q == SlotLast;
    sts_o.last_slot  = pos_q == SlotLast;
    sts_o.full       = count_q == CntMax;
  end

  // Entry count never passes the key limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntMax)
    else $error("entry count above key limit");

  // With entries stored, the tracked min key does not exceed the max key
  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> min_q <= max_q)
    else $error("min key above max key with entries stored");

  // A claimed slot bumps the count by exactly one
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |=> count_q == CntW'($past(count_q) + 1'b1))
    else $error("insert did not advance entry count");

endmodule

### rtl/core/lpkit_ctrl.sv
// Controller FSM: sequences hash, probe, insert and clear sweeps in the datapath.
// Owns the request/response handshakes and the pending status code.
// Depends on lpkit_pkg.
module lpkit_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lpkit_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  lpkit_pkg::sts_t sts_i,
  output lpkit_pkg::cmd_t cmd_o
);
  import lpkit_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,   // clearing pass after reset
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_SWEEP,  // clearing pass for a clear request
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               insert_q, insert_d;
  logic               out_valid_q, out_valid_d;
  logic               accept;

  assign in_ready_o  = state_q == ST_IDLE;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    status_d    = status_q;
    insert_d    = insert_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.last_slot) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.cap = 1'b1;
          insert_d  = in_req_i.mode == MODE_INSERT;
          priority if (in_req_i.mode == MODE_CLEAR) begin
            cmd_o.clr_regs = 1'b1;
            state_d        = ST_SWEEP;
          end else if (in_req_i.mode == MODE_NONE) begin
            state_d = ST_IDLE;
          end else if (in_req_i.key == '0) begin
            status_d = STS_ZERO;
            state_d  = ST_DONE;
          end else if (in_req_i.mode == MODE_INSERT && sts_i.full) begin
            cmd_o.minmax = 1'b1;
            status_d     = STS_FULL;
            state_d      = ST_DONE;
          end else begin
            cmd_o.minmax     = in_req_i.mode == MODE_INSERT;
            cmd_o.hash_start = 1'b1;
            state_d          = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.probe_init = 1'b1;
          state_d          = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (sts_i.key_match) begin
          cmd_o.hit = 1'b1;
          status_d  = insert_q ? STS_UPDATED : STS_FOUND;
          state_d   = ST_DONE;
        end else if (insert_q && sts_i.slot_empty) begin
          cmd_o.ins = 1'b1;
          status_d  = STS_NEW;
          state_d   = ST_DONE;
        end else if (sts_i.last_probe) begin
          status_d = insert_q ? STS_FULL : STS_ABSENT;
          state_d  = ST_DONE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = ST_READ;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.last_slot) begin
          status_d = STS_CLEARED;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the response once the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res        = 1'b1;
          cmd_o.res_status = status_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      status_q    <= STS_ZERO;
      insert_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      insert_q    <= insert_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Home slot only arrives while the FSM waits for it
  a_hash_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.hash_done |-> state_q == ST_HASH)
    else $error("hash result outside hash wait");

  // A pending response is never overwritten while blocked
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && !out_ready_i |=> state_q == ST_DONE)
    else $error("left done state while response stalled");

  // Every meaningful request starts work
  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_req_i.mode != MODE_NONE |=> state_q != ST_IDLE)
    else $error("accepted request produced no work");

endmodule
